[sv/assert_macros.svh]
// ----------------------------------------------------------------------------
// assert_macros.svh: shared concurrent assertion macros
// Assertions sampled on the rising clock edge, reporting through $error.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked outside reset only.
`define JSU_ASSERT(name, ck, rs, prop) \
  name: assert property (@(posedge ck) disable iff (rs) prop) \
    else $error("jsu assertion failed");

// Checked at every edge, reset included.
`define JSU_ASSERT_ALWAYS(name, ck, prop) \
  name: assert property (@(posedge ck) prop) \
    else $error("jsu assertion failed");

`endif

[sv/jsu_pkg.sv]
// ----------------------------------------------------------------------------
// jsu_pkg: shared types for the JSON string unescape block
// Result status codes, one result beat, and the bundle of beats per input.
// ----------------------------------------------------------------------------
package jsu_pkg;

  localparam int MAX_RES = 4;

  typedef enum logic [2:0] {
    ST_OK       = 3'd0,
    ST_END      = 3'd1,
    ST_BAD_ESC  = 3'd2,
    ST_BAD_HEX  = 3'd3,
    ST_BAD_PAIR = 3'd4,
    ST_UNTERM   = 3'd5
  } status_t;

  typedef struct packed {
    logic [7:0] data;
    logic       vld;
    status_t    status;
  } res_t;

  // cnt holds 1..MAX_RES for a bundle in the queue
  typedef struct packed {
    logic [2:0]           cnt;
    res_t [MAX_RES-1:0]   res;
  } bundle_t;

endpackage

[sv/jsu_if.sv]
// ----------------------------------------------------------------------------
// jsu_if: valid/ready channels of the unescape block
// Input channel carries raw body bytes, output channel carries result beats.
// ----------------------------------------------------------------------------
interface jsu_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;

  modport source (output valid, output data_byte, input ready);
  modport sink   (input valid, input data_byte, output ready);
endinterface

interface jsu_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       byte_valid;
  logic       last;
  logic [2:0] status;

  modport source (output valid, output out_byte, output byte_valid, output last,
                  output status, input ready);
  modport sink   (input valid, input out_byte, input byte_valid, input last,
                  input status, output ready);
endinterface

[sv/jsu_front.sv]
// ----------------------------------------------------------------------------
// jsu_front: escape decoder front end
// Takes one body byte per beat, tracks escape and surrogate state and builds
// the bundle of result beats that the byte causes.
// ----------------------------------------------------------------------------
module jsu_front (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata,
  jsu_in_if.sink            in_ch,
  input  logic              q_ready,
  output logic              push,
  output jsu_pkg::bundle_t  push_bundle
);

  typedef enum logic [2:0] {
    M_NORMAL   = 3'd0,
    M_ESCAPE   = 3'd1,
    M_HEX1     = 3'd2,
    M_LEAD     = 3'd3,
    M_LEAD_BSL = 3'd4,
    M_HEX2     = 3'd5
  } mode_t;

  localparam logic [7:0]  CH_QUOTE     = 8'h22;
  localparam logic [7:0]  CH_SLASH     = 8'h2F;
  localparam logic [7:0]  CH_BSL       = 8'h5C;
  localparam logic [7:0]  CH_SPACE     = 8'h20;
  localparam logic [7:0]  LETTER_RESET = 8'h78;
  localparam logic [15:0] SURR_MASK    = 16'hFC00;
  localparam logic [15:0] LEAD_BASE    = 16'hD800;
  localparam logic [15:0] TRAIL_BASE   = 16'hDC00;
  localparam logic [20:0] SUPP_BASE    = 21'h10000;

  typedef struct packed {
    logic       ok;
    logic [3:0] v;
  } hex_t;

  typedef struct packed {
    logic       ok;
    logic [7:0] c;
  } esc_t;

  function automatic hex_t hex_val(logic [7:0] b);
    hex_t r;
    r.ok = 1'b1;
    r.v  = b[3:0];
    if (b >= 8'h30 && b <= 8'h39) begin
      r.v = b[3:0];
    end else if ((b >= 8'h61 && b <= 8'h66) || (b >= 8'h41 && b <= 8'h46)) begin
      r.v = b[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic esc_t esc_char(logic [7:0] b);
    esc_t r;
    r.ok = 1'b1;
    case (b)
      CH_QUOTE, CH_SLASH, CH_BSL: r.c = b;
      8'h62:   r.c = 8'h08;  // b
      8'h66:   r.c = 8'h0C;  // f
      8'h6E:   r.c = 8'h0A;  // n
      8'h72:   r.c = 8'h0D;  // r
      8'h74:   r.c = 8'h09;  // t
      default: begin
        r.ok = 1'b0;
        r.c  = 8'h00;
      end
    endcase
    return r;
  endfunction

  function automatic jsu_pkg::bundle_t push_res(jsu_pkg::bundle_t bd, logic [7:0] d,
                                                logic v, jsu_pkg::status_t s);
    jsu_pkg::bundle_t r;
    r = bd;
    r.res[bd.cnt[1:0]] = '{data: d, vld: v, status: s};
    r.cnt = bd.cnt + 3'd1;
    return r;
  endfunction

  function automatic jsu_pkg::bundle_t push_cp(jsu_pkg::bundle_t bd, logic [20:0] cp);
    jsu_pkg::bundle_t r;
    r = bd;
    if (cp > 21'h00FFFF) begin
      r = push_res(r, {5'b11110, cp[20:18]}, 1'b1, jsu_pkg::ST_OK);
      r = push_res(r, {2'b10, cp[17:12]}, 1'b1, jsu_pkg::ST_OK);
      r = push_res(r, {2'b10, cp[11:6]}, 1'b1, jsu_pkg::ST_OK);
      r = push_res(r, {2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_OK);
    end else if (cp > 21'h0007FF) begin
      r = push_res(r, {4'b1110, cp[15:12]}, 1'b1, jsu_pkg::ST_OK);
      r = push_res(r, {2'b10, cp[11:6]}, 1'b1, jsu_pkg::ST_OK);
      r = push_res(r, {2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_OK);
    end else if (cp > 21'h00007F) begin
      r = push_res(r, {3'b110, cp[10:6]}, 1'b1, jsu_pkg::ST_OK);
      r = push_res(r, {2'b10, cp[5:0]}, 1'b1, jsu_pkg::ST_OK);
    end else begin
      r = push_res(r, cp[7:0], 1'b1, jsu_pkg::ST_OK);
    end
    return r;
  endfunction

  mode_t            mode, mode_next;
  logic [1:0]       hex_cnt, hex_cnt_next;
  logic [11:0]      acc, acc_next;
  logic [9:0]       lead, lead_next;
  logic [7:0]       esc_letter;

  logic             fire;
  logic [7:0]       b;
  hex_t             hv;
  esc_t             ec;
  logic [15:0]      unit;
  logic [20:0]      pair_cp;
  logic [20:0]      lead_cp;
  logic             run_norm, run_esc, go_idle;
  jsu_pkg::bundle_t bd;

  assign b           = in_ch.data_byte;
  assign in_ch.ready = q_ready;
  assign fire        = in_ch.valid && q_ready;
  assign hv          = hex_val(b);
  assign ec          = esc_char(b);
  assign unit        = {acc, hv.v};
  assign pair_cp     = {1'b0, lead, unit[9:0]} + SUPP_BASE;
  assign lead_cp     = {5'd0, LEAD_BASE[15:10], lead};

  always_comb begin
    mode_next    = mode;
    hex_cnt_next = hex_cnt;
    acc_next     = acc;
    lead_next    = lead;
    run_norm     = 1'b0;
    run_esc      = 1'b0;
    go_idle      = 1'b0;
    bd           = '0;

    case (mode)
      M_ESCAPE: run_esc = 1'b1;
      M_HEX1, M_HEX2: begin
        if (!hv.ok) begin
          bd      = push_res(bd, 8'h00, 1'b0, jsu_pkg::ST_BAD_HEX);
          go_idle = 1'b1;
        end else if (hex_cnt == 2'd3) begin
          hex_cnt_next = 2'd0;
          acc_next     = '0;
          if (mode == M_HEX1) begin
            if ((unit & SURR_MASK) == LEAD_BASE) begin
              lead_next = unit[9:0];
              mode_next = M_LEAD;
            end else begin
              bd        = push_cp(bd, {5'd0, unit});
              mode_next = M_NORMAL;
            end
          end else if ((unit & SURR_MASK) != TRAIL_BASE) begin
            bd      = push_res(bd, 8'h00, 1'b0, jsu_pkg::ST_BAD_PAIR);
            go_idle = 1'b1;
          end else begin
            bd      = push_cp(bd, pair_cp);
            go_idle = 1'b1;
          end
        end else begin
          acc_next     = unit[11:0];
          hex_cnt_next = hex_cnt + 2'd1;
        end
      end
      M_LEAD: begin
        if (b == CH_BSL) begin
          mode_next = M_LEAD_BSL;
        end else begin
          bd        = push_cp(bd, lead_cp);
          lead_next = '0;
          mode_next = M_NORMAL;
          run_norm  = 1'b1;
        end
      end
      M_LEAD_BSL: begin
        if (b == esc_letter) begin
          mode_next    = M_HEX2;
          hex_cnt_next = 2'd0;
          acc_next     = '0;
        end else begin
          bd        = push_cp(bd, lead_cp);
          lead_next = '0;
          run_esc   = 1'b1;
        end
      end
      default: begin
        mode_next = M_NORMAL;
        run_norm  = 1'b1;
      end
    endcase

    // byte after a backslash; the unit escape letter wins over fixed escapes
    if (run_esc) begin
      if (b == esc_letter) begin
        mode_next    = M_HEX1;
        hex_cnt_next = 2'd0;
        acc_next     = '0;
      end else if (ec.ok) begin
        bd        = push_res(bd, ec.c, 1'b1, jsu_pkg::ST_OK);
        mode_next = M_NORMAL;
      end else begin
        bd      = push_res(bd, 8'h00, 1'b0, jsu_pkg::ST_BAD_ESC);
        go_idle = 1'b1;
      end
    end

    if (run_norm) begin
      if (b == CH_QUOTE) begin
        bd      = push_res(bd, 8'h00, 1'b0, jsu_pkg::ST_END);
        go_idle = 1'b1;
      end else if (b < CH_SPACE) begin
        bd      = push_res(bd, 8'h00, 1'b0, jsu_pkg::ST_UNTERM);
        go_idle = 1'b1;
      end else if (b == CH_BSL) begin
        mode_next = M_ESCAPE;
      end else begin
        bd = push_res(bd, b, 1'b1, jsu_pkg::ST_OK);
      end
    end

    if (go_idle) begin
      mode_next    = M_NORMAL;
      hex_cnt_next = 2'd0;
      acc_next     = '0;
      lead_next    = '0;
    end
  end

  assign push        = fire && (bd.cnt != 3'd0);
  assign push_bundle = bd;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_NORMAL;
      hex_cnt    <= 2'd0;
      acc        <= '0;
      lead       <= '0;
      esc_letter <= LETTER_RESET;
    end else begin
      if (cfg_we) begin
        esc_letter <= cfg_wdata;
      end
      if (fire) begin
        mode    <= mode_next;
        hex_cnt <= hex_cnt_next;
        acc     <= acc_next;
        lead    <= lead_next;
      end
    end
  end

endmodule

[sv/jsu_queue.sv]
// ----------------------------------------------------------------------------
// jsu_queue: bundle queue between decoder and serializer
// Small register FIFO; ready depends on fill level only.
// ----------------------------------------------------------------------------
module jsu_queue #(
  parameter int DEPTH = 4
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  jsu_pkg::bundle_t  wr_bundle,
  output logic              ready,
  output logic              valid,
  output jsu_pkg::bundle_t  rd_bundle,
  input  logic              pop
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  jsu_pkg::bundle_t mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push, do_pop;

  assign ready     = (count != CW'(DEPTH));
  assign valid     = (count != '0);
  assign rd_bundle = mem[rd_ptr];
  assign do_push   = push && ready;
  assign do_pop    = pop && valid;

  function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] p);
    return (p == AW'(DEPTH - 1)) ? '0 : p + AW'(1);
  endfunction

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wr_bundle;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wrap_inc(wr_ptr);
      end
      if (do_pop) begin
        rd_ptr <= wrap_inc(rd_ptr);
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + CW'(1);
        2'b01:   count <= count - CW'(1);
        default: count <= count;
      endcase
    end
  end

endmodule

[sv/jsu_back.sv]
// ----------------------------------------------------------------------------
// jsu_back: result serializer
// Walks the head bundle one beat at a time and flags the final beat.
// ----------------------------------------------------------------------------
module jsu_back (
  input  logic              clk,
  input  logic              rst,
  input  logic              q_valid,
  input  jsu_pkg::bundle_t  head,
  output logic              pop,
  jsu_out_if.source         out_ch
);

  logic [1:0]     idx;
  jsu_pkg::res_t  cur;
  logic           is_last;
  logic           fire;

  assign cur     = head.res[idx];
  assign is_last = ({1'b0, idx} == (head.cnt - 3'd1));
  assign fire    = q_valid && out_ch.ready;
  assign pop     = fire && is_last;

  assign out_ch.valid      = q_valid;
  assign out_ch.out_byte   = cur.data;
  assign out_ch.byte_valid = cur.vld;
  assign out_ch.last       = is_last;
  assign out_ch.status     = cur.status;

  always_ff @(posedge clk) begin
    if (rst) begin
      idx <= 2'd0;
    end else if (fire) begin
      idx <= is_last ? 2'd0 : idx + 2'd1;
    end
  end

endmodule

[sv/json_string_unescape_utf8.sv]
// ----------------------------------------------------------------------------
// json_string_unescape_utf8: JSON string body unescape to UTF-8 bytes
// First result beat of a byte goes through the registered queue, behind older bundles.
// Throughput: one input byte per cycle while the queue has room; n results are n beats.
// Reset (rst, synchronous): normal body mode, queue empty, escape letter 'x'.
// ----------------------------------------------------------------------------
module json_string_unescape_utf8 #(
  // bundles buffered between decoder and serializer
  parameter int QUEUE_DEPTH = 4
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  jsu_in_if.sink     in_ch,
  jsu_out_if.source  out_ch
);

  // Front: decodes each body byte in the cycle it is taken and produces a
  // bundle of 0..4 result beats (lead surrogate flush plus what follows, or a
  // four-byte UTF-8 code point). Bytes that cause nothing, like a backslash or
  // a hex digit, only move the decoder state and never enter the queue.
  logic             push;
  jsu_pkg::bundle_t push_bundle;
  logic             q_ready;

  // Queue: holds whole bundles, so a multi-beat burst on the output does not
  // stop the input while there is room. Input ready follows fill level only;
  // no combinational path from out_ch.ready to in_ch.ready.
  logic             q_valid;
  jsu_pkg::bundle_t head;
  logic             pop;

  jsu_front u_front (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_wdata   (cfg_wdata),
    .in_ch       (in_ch),
    .q_ready     (q_ready),
    .push        (push),
    .push_bundle (push_bundle)
  );

  jsu_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .wr_bundle (push_bundle),
    .ready     (q_ready),
    .valid     (q_valid),
    .rd_bundle (head),
    .pop       (pop)
  );

  // Back: one result beat per output handshake; the bundle is popped on its
  // last beat, which also carries the last flag.
  jsu_back u_back (
    .clk     (clk),
    .rst     (rst),
    .q_valid (q_valid),
    .head    (head),
    .pop     (pop),
    .out_ch  (out_ch)
  );

endmodule

[sv/jsu_checker.sv]
// ----------------------------------------------------------------------------
// jsu_checker: port level checks for the unescape block
// Output beat consistency and stall behavior, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module jsu_checker (
  input logic       clk,
  input logic       rst,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       byte_valid,
  input logic       last,
  input logic [2:0] status
);

  // a stalled beat holds
  `JSU_ASSERT(a_out_hold, clk, rst, out_valid && !out_ready |=> out_valid && $stable(out_byte) && $stable(byte_valid) && $stable(last) && $stable(status))

  // a status beat carries no byte and closes its input byte's results
  `JSU_ASSERT(a_status_last, clk, rst, out_valid && (status != jsu_pkg::ST_OK) |-> !byte_valid && last)

  // every beat is either a byte or a status
  `JSU_ASSERT(a_byte_or_status, clk, rst, out_valid && !byte_valid |-> status != jsu_pkg::ST_OK)

  // reset empties the output side
  `JSU_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)

endmodule

bind json_string_unescape_utf8 jsu_checker u_jsu_checker (
  .clk        (clk),
  .rst        (rst),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_byte   (out_ch.out_byte),
  .byte_valid (out_ch.byte_valid),
  .last       (out_ch.last),
  .status     (out_ch.status)
);

[tb/tb_json_string_unescape_utf8.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_json_string_unescape_utf8: self-checking bench for the string unescaper
// Feeds string body bytes through a valid/ready source with random gaps, runs
// its own decoder to predict every UTF-8/status beat, and compares each beat
// taken from the output (randomly stalled) against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_json_string_unescape_utf8;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int PHASE_BYTES    = 30;
  localparam int SETTLE_CYCLES  = 8;

  localparam logic [15:0] SURR_MASK  = 16'hFC00;
  localparam logic [15:0] LEAD_BASE  = 16'hD800;
  localparam logic [15:0] LEAD_TOP   = 16'hDBFF;
  localparam logic [15:0] TRAIL_BASE = 16'hDC00;
  localparam logic [15:0] TRAIL_TOP  = 16'hDFFF;

  localparam logic [7:0] SIMPLE_ESC [8] = '{"\"", "/", "\\", "b", "f", "n", "r", "t"};
  localparam logic [15:0] BMP_EDGES [8] = '{16'h0000, 16'h007F, 16'h0080, 16'h07FF,
                                            16'h0800, 16'hD7FF, 16'hE000, 16'hFFFF};

  // decoder states of the predictor
  typedef enum logic [2:0] {
    DM_BODY, DM_ESC, DM_HEX1, DM_LEAD, DM_LEAD_BSL, DM_HEX2
  } dec_mode_t;

  // one output beat as predicted
  typedef struct packed {
    logic [7:0]       data;
    logic             vld;
    logic             last;
    jsu_pkg::status_t status;
  } beat_t;

  logic       clk;
  logic       rst;
  logic       cfg_we;
  logic [7:0] cfg_wdata;

  jsu_in_if  in_ch ();
  jsu_out_if out_ch ();

  json_string_unescape_utf8 u_dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_ch     (in_ch),
    .out_ch    (out_ch)
  );

  always #5 clk = ~clk;

  // --------------------------------------------------------------------------
  // Predictor state: mirrors the decoder, updated once per accepted input beat
  // --------------------------------------------------------------------------
  dec_mode_t   dmode;
  logic [1:0]  ndigits;
  logic [15:0] hex_acc;
  logic [15:0] lead_unit;
  logic [7:0]  esc_letter;

  beat_t      step_beats[$];   // beats caused by the byte being decoded
  beat_t      decoded_q[$];    // predicted beats not yet seen at the output
  logic [7:0] body_bytes_q[$]; // bytes waiting for the input driver

  int  fed_count;
  int  err_count;
  int  out_count;
  int  in_gap;
  int  out_stall;
  int  idle_cycles;
  bit  calm;                   // phase without any gaps or stalls
  beat_t head_beat;

  function automatic int hex_nibble(logic [7:0] b);
    if (b >= "0" && b <= "9") return int'(b - "0");
    if (b >= "a" && b <= "f") return int'(b - "a") + 10;
    if (b >= "A" && b <= "F") return int'(b - "A") + 10;
    return -1;
  endfunction

  task automatic put_beat(input logic [7:0] d, input logic v, input jsu_pkg::status_t s);
    if (step_beats.size() < jsu_pkg::MAX_RES) step_beats.push_back('{d, v, 1'b0, s});
  endtask

  task automatic go_body();
    dmode     = DM_BODY;
    ndigits   = '0;
    hex_acc   = '0;
    lead_unit = '0;
  endtask

  // a status beat carries no byte and always drops back to body mode
  task automatic fail_with(input jsu_pkg::status_t s);
    put_beat(8'h00, 1'b0, s);
    go_body();
  endtask

  task automatic put_code_point(input int unsigned cp);
    if (cp > 32'hFFFF) begin
      put_beat(8'(32'hF0 + (cp >> 18)), 1'b1, jsu_pkg::ST_OK);
      put_beat(8'(32'h80 + ((cp >> 12) & 32'h3F)), 1'b1, jsu_pkg::ST_OK);
      put_beat(8'(32'h80 + ((cp >> 6) & 32'h3F)), 1'b1, jsu_pkg::ST_OK);
      put_beat(8'(32'h80 + (cp & 32'h3F)), 1'b1, jsu_pkg::ST_OK);
    end else if (cp > 32'h07FF) begin
      put_beat(8'(32'hE0 + (cp >> 12)), 1'b1, jsu_pkg::ST_OK);
      put_beat(8'(32'h80 + ((cp >> 6) & 32'h3F)), 1'b1, jsu_pkg::ST_OK);
      put_beat(8'(32'h80 + (cp & 32'h3F)), 1'b1, jsu_pkg::ST_OK);
    end else if (cp > 32'h7F) begin
      put_beat(8'(32'hC0 + (cp >> 6)), 1'b1, jsu_pkg::ST_OK);
      put_beat(8'(32'h80 + (cp & 32'h3F)), 1'b1, jsu_pkg::ST_OK);
    end else begin
      put_beat(8'(cp), 1'b1, jsu_pkg::ST_OK);
    end
  endtask

  task automatic body_step(input logic [7:0] b);
    if (b == "\"") fail_with(jsu_pkg::ST_END);
    else if (b < 8'h20) fail_with(jsu_pkg::ST_UNTERM);
    else if (b == "\\") dmode = DM_ESC;
    else put_beat(b, 1'b1, jsu_pkg::ST_OK);
  endtask

  // code unit escape wins over the fixed escapes when the letter collides
  task automatic escape_step(input logic [7:0] b);
    logic [7:0] c;
    if (b == esc_letter) begin
      dmode   = DM_HEX1;
      ndigits = '0;
      hex_acc = '0;
    end else begin
      case (b)
        "\"", "/", "\\": c = b;
        "b": c = 8'h08;
        "f": c = 8'h0C;
        "n": c = 8'h0A;
        "r": c = 8'h0D;
        "t": c = 8'h09;
        default: c = 8'h00;
      endcase
      if (b inside {"\"", "/", "\\", "b", "f", "n", "r", "t"}) begin
        put_beat(c, 1'b1, jsu_pkg::ST_OK);
        dmode = DM_BODY;
      end else begin
        fail_with(jsu_pkg::ST_BAD_ESC);
      end
    end
  endtask

  task automatic hex_step(input logic [7:0] b, output logic done, output logic bad);
    int v;
    v    = hex_nibble(b);
    done = 1'b0;
    bad  = (v < 0);
    if (!bad) begin
      hex_acc = {hex_acc[11:0], 4'(v)};
      if (ndigits == 2'd3) begin
        ndigits = '0;
        done    = 1'b1;
      end else begin
        ndigits = ndigits + 2'd1;
      end
    end
  endtask

  // Works out every beat that one input byte causes and queues them in order.
  task automatic decode_byte(input logic [7:0] b);
    logic        done;
    logic        bad;
    logic [15:0] cu;
    int unsigned cp;
    step_beats.delete();
    case (dmode)
      DM_ESC: escape_step(b);
      DM_HEX1: begin
        hex_step(b, done, bad);
        if (done) begin
          cu      = hex_acc;
          hex_acc = '0;
          if ((cu & SURR_MASK) == LEAD_BASE) begin
            lead_unit = cu;
            dmode     = DM_LEAD;
          end else begin
            put_code_point(32'(cu));
            dmode = DM_BODY;
          end
        end else if (bad) begin
          fail_with(jsu_pkg::ST_BAD_HEX);
        end
      end
      DM_LEAD: begin
        if (b == "\\") begin
          dmode = DM_LEAD_BSL;
        end else begin
          // lead without a second escape goes out alone
          put_code_point(32'(lead_unit));
          lead_unit = '0;
          dmode     = DM_BODY;
          body_step(b);
        end
      end
      DM_LEAD_BSL: begin
        if (b == esc_letter) begin
          dmode   = DM_HEX2;
          ndigits = '0;
          hex_acc = '0;
        end else begin
          put_code_point(32'(lead_unit));
          lead_unit = '0;
          escape_step(b);
        end
      end
      DM_HEX2: begin
        hex_step(b, done, bad);
        if (done) begin
          cu = hex_acc;
          if ((cu & SURR_MASK) != TRAIL_BASE) begin
            fail_with(jsu_pkg::ST_BAD_PAIR);
          end else begin
            cp = (((32'(lead_unit) - 32'hD800) & 32'h3FF) << 10)
                 + (32'(cu) - 32'hDC00) + 32'h10000;
            put_code_point(cp);
            go_body();
          end
        end else if (bad) begin
          fail_with(jsu_pkg::ST_BAD_HEX);
        end
      end
      default: begin
        dmode = DM_BODY;
        body_step(b);
      end
    endcase
    foreach (step_beats[i]) begin
      step_beats[i].last = (i == step_beats.size() - 1);
      decoded_q.push_back(step_beats[i]);
    end
  endtask

  // --------------------------------------------------------------------------
  // Stimulus helpers
  // --------------------------------------------------------------------------
  // mostly back-to-back, sometimes a few cycles, rarely a long hole
  function automatic int idle_len();
    int r;
    if (calm) return 0;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] n);
    if (n < 4'd10) return 8'("0" + n);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + n - 4'd10);
  endfunction

  function automatic logic [7:0] rand_plain();
    logic [7:0] b;
    do b = 8'($urandom_range(32, 255)); while (b == "\"" || b == "\\");
    return b;
  endfunction

  function automatic logic [7:0] rand_bad_esc();
    logic [7:0] b;
    do b = 8'($urandom_range(0, 255));
    while (b == esc_letter || b inside {"\"", "/", "\\", "b", "f", "n", "r", "t"});
    return b;
  endfunction

  function automatic logic [15:0] rand_bmp();
    case ($urandom_range(0, 4))
      0: return 16'($urandom_range(0, 16'h7F));
      1: return 16'($urandom_range(16'h80, 16'h7FF));
      2: return 16'($urandom_range(16'h800, 16'hD7FF));
      3: return 16'($urandom_range(16'hE000, 16'hFFFF));
      default: return BMP_EDGES[$urandom_range(0, 7)];
    endcase
  endfunction

  function automatic logic [15:0] rand_lead();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? LEAD_BASE : LEAD_TOP;
    return 16'($urandom_range(LEAD_BASE, LEAD_TOP));
  endfunction

  function automatic logic [15:0] rand_trail();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 1) ? TRAIL_BASE : TRAIL_TOP;
    return 16'($urandom_range(TRAIL_BASE, TRAIL_TOP));
  endfunction

  task automatic feed(input logic [7:0] b);
    body_bytes_q.push_back(b);
    fed_count++;
  endtask

  // backslash, escape letter, four hex digits in mixed case
  task automatic feed_unit(input logic [15:0] cu);
    feed("\\");
    feed(esc_letter);
    for (int i = 3; i >= 0; i--) feed(hex_char(cu[i*4 +: 4]));
  endtask

  // Mostly well-formed pieces of a string body, plus broken escapes and noise.
  task automatic gen_random(input int n);
    int          kind;
    int          start;
    logic [7:0]  b;
    logic [15:0] cu;
    start = fed_count;
    while (fed_count - start < n) begin
      kind = $urandom_range(0, 99);
      if (kind < 30) begin
        repeat ($urandom_range(1, 4)) feed(rand_plain());
      end else if (kind < 45) begin
        feed("\\");
        feed(SIMPLE_ESC[$urandom_range(0, 7)]);
      end else if (kind < 60) begin
        feed_unit(rand_bmp());
      end else if (kind < 70) begin
        feed_unit(rand_lead());
        feed_unit(rand_trail());
      end else if (kind < 73) begin
        // lone lead ended by an ordinary byte, a quote or a control byte
        feed_unit(rand_lead());
        case ($urandom_range(0, 2))
          0: feed(rand_plain());
          1: feed("\"");
          default: feed(8'($urandom_range(0, 31)));
        endcase
      end else if (kind < 75) begin
        // lone lead followed by a fixed or broken escape
        feed_unit(rand_lead());
        feed("\\");
        if ($urandom_range(0, 1)) feed(SIMPLE_ESC[$urandom_range(0, 7)]);
        else feed(rand_bad_esc());
      end else if (kind < 77) begin
        feed_unit(rand_trail());
      end else if (kind < 79) begin
        // lead followed by a second unit that is not a trail
        feed_unit(rand_lead());
        do cu = 16'($urandom); while ((cu & SURR_MASK) == TRAIL_BASE);
        feed_unit(cu);
      end else if (kind < 81) begin
        // non-hex byte somewhere among the four digits
        if ($urandom_range(0, 1)) feed_unit(rand_lead());
        feed("\\");
        feed(esc_letter);
        repeat ($urandom_range(0, 3)) feed(hex_char(4'($urandom)));
        do b = 8'($urandom); while (hex_nibble(b) >= 0);
        feed(b);
      end else if (kind < 84) begin
        feed("\\");
        feed(rand_bad_esc());
      end else if (kind < 88) begin
        feed("\"");
      end else if (kind < 91) begin
        feed(8'($urandom_range(0, 31)));
      end else begin
        feed(8'($urandom_range(0, 255)));
      end
    end
  endtask

  // wait until every byte is taken and every predicted beat has come out,
  // then let a byte that causes no beat finish inside the block
  task automatic wait_drained();
    do @(negedge clk);
    while (body_bytes_q.size() != 0 || in_ch.valid || decoded_q.size() != 0);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_letter(input logic [7:0] v);
    @(posedge clk);
    cfg_we     <= 1'b1;
    cfg_wdata  <= v;
    esc_letter = v;
    @(posedge clk);
    cfg_we     <= 1'b0;
  endtask

  task automatic note_error(input string msg);
    if (err_count < 10) $display("ERROR: %s", msg);
    err_count++;
  endtask

  // --------------------------------------------------------------------------
  // Input driver: a new beat is presented once the previous one is taken and
  // the drawn gap has run out; the predictor runs on every accepted beat.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      in_ch.valid <= 1'b0;
      in_gap      <= 0;
    end else begin
      if (in_ch.valid && in_ch.ready) decode_byte(in_ch.data_byte);
      if (!in_ch.valid || in_ch.ready) begin
        if (in_gap > 0) begin
          in_ch.valid <= 1'b0;
          in_gap      <= in_gap - 1;
        end else if (body_bytes_q.size() > 0) begin
          in_ch.valid     <= 1'b1;
          in_ch.data_byte <= body_bytes_q.pop_front();
          in_gap          <= idle_len();
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // --------------------------------------------------------------------------
  // Output monitor: every taken beat must match the oldest prediction
  // field by field; ready drops for random stretches.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst) begin
      out_ch.ready <= 1'b0;
      out_stall    <= 0;
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (decoded_q.size() == 0) begin
          note_error($sformatf("beat %0d unexpected: data=%h vld=%b last=%b status=%0d",
                               out_count, out_ch.out_byte, out_ch.byte_valid,
                               out_ch.last, out_ch.status));
        end else begin
          head_beat = decoded_q.pop_front();
          if (out_ch.out_byte !== head_beat.data || out_ch.byte_valid !== head_beat.vld ||
              out_ch.last !== head_beat.last || out_ch.status !== head_beat.status) begin
            note_error($sformatf({"beat %0d: expected data=%h vld=%b last=%b status=%0d,",
                                  " got data=%h vld=%b last=%b status=%0d"},
                                 out_count, head_beat.data, head_beat.vld, head_beat.last,
                                 head_beat.status, out_ch.out_byte, out_ch.byte_valid,
                                 out_ch.last, out_ch.status));
          end
        end
        out_count++;
      end
      if (out_stall > 0) begin
        out_ch.ready <= 1'b0;
        out_stall    <= out_stall - 1;
      end else begin
        out_ch.ready <= 1'b1;
        out_stall    <= idle_len();
      end
    end
  end

  // Watchdog: ends a run that stops moving beats on both channels.
  always @(posedge clk) begin
    if (rst) begin
      idle_cycles <= 0;
    end else if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // --------------------------------------------------------------------------
  // Test sequence
  // --------------------------------------------------------------------------
  initial begin
    logic [7:0] letters [7];
    clk             = 1'b0;
    rst             = 1'b1;
    cfg_we          = 1'b0;
    cfg_wdata       = '0;
    in_ch.valid     = 1'b0;
    in_ch.data_byte = '0;
    out_ch.ready    = 1'b0;
    calm            = 1'b0;
    fed_count       = 0;
    err_count       = 0;
    out_count       = 0;
    esc_letter      = "x";      // reset value of the escape letter
    go_body();

    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // directed part on the reset letter: top plain byte, a fixed escape,
    // largest two-byte code point, a surrogate pair to four bytes, end quote,
    // a NUL as unterminated, and an unknown escape
    feed(8'hFF);
    feed("\\");
    feed("t");
    feed_unit(16'h07FF);
    feed_unit(16'hD83D);
    feed_unit(16'hDE00);
    feed("\"");
    feed(8'h00);
    feed("\\");
    feed("q");
    wait_drained();

    // escape letter settings: usual 'u', both extremes, collisions with the
    // fixed escapes (quote and backslash), a random one, back to 'x'
    letters = '{"u", 8'h00, 8'hFF, "\"", "\\", 8'($urandom_range(0, 255)), "x"};
    foreach (letters[p]) begin
      write_letter(letters[p]);
      calm = (p == 2 || p == 5);
      gen_random(PHASE_BYTES);
      wait_drained();
    end

    repeat (20) @(negedge clk);
    if (decoded_q.size() != 0)
      note_error($sformatf("%0d predicted beats never arrived", decoded_q.size()));
    if (err_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
